// ----- rtl/b64e_pkg.sv -----
package b64e_pkg;

  localparam int CharW      = 8;
  localparam int MaxChars   = 4;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);
  localparam int IdxW       = $clog2(MaxChars);
  localparam int CountW     = $clog2(MaxChars + 1);

  localparam logic [CharW-1:0] PadChar = 8'h3D;

  typedef enum logic [1:0] {
    PHASE_0 = 2'd0,
    PHASE_1 = 2'd1,
    PHASE_2 = 2'd2,
    PHASE_X = 2'd3
  } phase_t;

  // one decoded input byte: the characters it produces, in emit order
  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [CountW-1:0]              count;
    logic                           last;
  } cmd_t;

  function automatic logic [CharW-1:0] sym(input logic [5:0] v);
    logic [CharW-1:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ----- rtl/b64e_front.sv -----
module b64e_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              in_ready,
  input  logic              cfg_valid,
  input  logic              cfg_data,
  input  logic              q_full,
  output logic              push,
  output b64e_pkg::cmd_t    push_cmd
);
  import b64e_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;
  logic       pad_en_r;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept;

  always_comb begin
    push_cmd       = '0;
    push_cmd.last  = in_last;
    phase_nxt      = phase_r;
    carry_nxt      = carry_r;
    unique case (phase_r)
      PHASE_1: begin
        push_cmd.chars[0] = sym({carry_r[1:0], in_byte[7:4]});
        push_cmd.count    = CountW'(1);
        carry_nxt         = in_byte[3:0];
        phase_nxt         = PHASE_2;
        if (in_last) begin
          push_cmd.chars[1] = sym({in_byte[3:0], 2'b00});
          push_cmd.chars[2] = PadChar;
          push_cmd.count    = pad_en_r ? CountW'(3) : CountW'(2);
        end
      end
      PHASE_2: begin
        push_cmd.chars[0] = sym({carry_r, in_byte[7:6]});
        push_cmd.chars[1] = sym(in_byte[5:0]);
        push_cmd.count    = CountW'(2);
        carry_nxt         = '0;
        phase_nxt         = PHASE_0;
      end
      default: begin
        push_cmd.chars[0] = sym(in_byte[7:2]);
        push_cmd.count    = CountW'(1);
        carry_nxt         = {2'b00, in_byte[1:0]};
        phase_nxt         = PHASE_1;
        if (in_last) begin
          push_cmd.chars[1] = sym({in_byte[1:0], 4'b0000});
          push_cmd.chars[2] = PadChar;
          push_cmd.chars[3] = PadChar;
          push_cmd.count    = pad_en_r ? CountW'(4) : CountW'(2);
        end
      end
    endcase
    if (in_last) begin
      phase_nxt = PHASE_0;
      carry_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PHASE_0;
      carry_r  <= '0;
      pad_en_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        carry_r <= carry_nxt;
      end
      if (cfg_valid) begin
        pad_en_r <= cfg_data;
      end
    end
  end

endmodule

// ----- rtl/b64e_queue.sv -----
module b64e_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64e_pkg::cmd_t push_cmd,
  input  logic           pop,
  output b64e_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);
  import b64e_pkg::*;

  cmd_t             mem_r [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] cnt_r;

  assign full  = (cnt_r == QCntW'(QueueDepth));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/b64e_back.sv -----
module b64e_back (
  input  logic           clk,
  input  logic           rst_n,
  input  b64e_pkg::cmd_t head,
  input  logic           q_empty,
  output logic           pop,
  output logic           out_valid,
  output logic [7:0]     out_char,
  output logic           out_last,
  input  logic           out_ready
);
  import b64e_pkg::*;

  logic [IdxW-1:0] idx_r;
  logic            out_valid_r;
  logic [7:0]      out_char_r;
  logic            out_last_r;
  logic            load;
  logic            final_char;

  assign load       = !q_empty && (!out_valid_r || out_ready);
  assign final_char = ((head.count - 1'b1) == CountW'(idx_r));
  assign pop        = load && final_char;

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r <= head.chars[idx_r];
      out_last_r <= head.last && final_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= final_char ? '0 : idx_r + 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/base64_stream_encoder_unit.sv -----
// Base64 stream encoder: bytes enter on the in_ stream, with in_tlast on the final
// byte of a message, and standard base64 characters leave on the out_ stream, one
// per cycle while out_tready is high, with out_tlast on the final character. A byte
// makes one character as the first or second byte of a group, two as the third,
// and up to four as a final byte when the leftover bits are flushed and '=' pads
// follow (cfg_data = 1 enables padding). A two-entry queue separates byte decoding
// from character output, so input is taken while the output is stalled until the
// queue fills. Write cfg only when idle.
module base64_stream_encoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // data_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_char
  output logic       out_tlast,  // last_char
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data    // pad_enable
);
  import b64e_pkg::*;

  logic push, pop, q_full, q_empty;
  cmd_t push_cmd, head;

  assign cfg_ready = 1'b1;

  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .in_ready  (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  b64e_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_char  (out_tdata),
    .out_last  (out_tlast),
    .out_ready (out_tready)
  );

endmodule

// ----- rtl/b64e_checker.sv -----
module b64e_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       cfg_ready
);

  // held output stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // every character is in the alphabet or a pad
  a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata >= 8'h41 && out_tdata <= 8'h5A) ||
                    (out_tdata >= 8'h61 && out_tdata <= 8'h7A) ||
                    (out_tdata >= 8'h30 && out_tdata <= 8'h39) ||
                    out_tdata == 8'h2B || out_tdata == 8'h2F || out_tdata == 8'h3D))
    else $error("illegal output character");

  // reset leaves nothing pending on the output
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // reset leaves the queue empty so input is open
  a_reset_in: assert property (@(posedge clk) !rst_n |=> in_tready && cfg_ready)
    else $error("input not ready after reset");

endmodule

bind base64_stream_encoder_unit b64e_checker u_b64e_checker (.*);

// ----- sim/tb_base64_stream_encoder_unit.sv -----
`timescale 1ns / 1ps

module tb_base64_stream_encoder_unit;
  import b64e_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DIR_N       = 25;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 30;

  localparam bit [0:63][CharW-1:0] B64_SET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             fin;
  } char_t;

  // directed row: pad setting, byte, last flag, typed check, char count, text
  typedef struct packed {
    logic             pad;
    logic [7:0]       b;
    logic             fin;
    logic             chk;
    logic [2:0]       cnt;
    logic [31:0]      text;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{1'b0, 8'h4D, 1'b0, 1'b1, 3'd1, "T"},
    '{1'b0, 8'h61, 1'b0, 1'b1, 3'd1, "W"},
    '{1'b0, 8'h6E, 1'b1, 1'b1, 3'd2, "Fu"},
    '{1'b0, 8'h00, 1'b1, 1'b1, 3'd2, "AA"},
    '{1'b0, 8'hFF, 1'b1, 1'b1, 3'd2, "/w"},
    '{1'b0, 8'hFB, 1'b0, 1'b0, 3'd0, 32'h0},
    '{1'b0, 8'hEF, 1'b0, 1'b0, 3'd0, 32'h0},
    '{1'b0, 8'hBE, 1'b1, 1'b0, 3'd0, 32'h0},
    '{1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 32'h0},
    '{1'b0, 8'hFF, 1'b1, 1'b0, 3'd0, 32'h0},
    '{1'b0, 8'h80, 1'b0, 1'b0, 3'd0, 32'h0},
    '{1'b0, 8'h01, 1'b0, 1'b0, 3'd0, 32'h0},
    '{1'b0, 8'h7F, 1'b1, 1'b0, 3'd0, 32'h0},
    '{1'b1, 8'hFF, 1'b1, 1'b1, 3'd4, "/w=="},
    '{1'b1, 8'h00, 1'b0, 1'b1, 3'd1, "A"},
    '{1'b1, 8'h00, 1'b1, 1'b1, 3'd3, "AA="},
    '{1'b1, 8'hFF, 1'b0, 1'b1, 3'd1, "/"},
    '{1'b1, 8'hFF, 1'b0, 1'b1, 3'd1, "/"},
    '{1'b1, 8'hFF, 1'b1, 1'b1, 3'd2, "//"},
    '{1'b1, 8'h4D, 1'b0, 1'b1, 3'd1, "T"},
    '{1'b1, 8'h61, 1'b1, 1'b1, 3'd3, "WE="},
    '{1'b1, 8'h55, 1'b0, 1'b0, 3'd0, 32'h0},
    '{1'b1, 8'hAA, 1'b0, 1'b0, 3'd0, 32'h0},
    '{1'b1, 8'h3C, 1'b1, 1'b0, 3'd0, 32'h0},
    '{1'b1, 8'h0F, 1'b1, 1'b0, 3'd0, 32'h0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // data_byte
  logic       in_tlast = 1'b0;    // last_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // out_char
  logic       out_tlast;          // last_char
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;    // pad_enable

  // encoder model state
  phase_t     grp_phase = PHASE_0;
  logic [3:0] carry_nib = 4'h0;
  logic       pad_on = 1'b0;

  char_t      chars_due[$];
  int         in_cnt = 0;
  int         mismatch_cnt = 0;
  int         cycle_cnt = 0;
  int         stall_left = 0;
  logic       pad_cur = 1'b0;
  bit         burst = 1'b0;

  base64_stream_encoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int encode_byte(input logic [7:0] b, input logic fin,
                                     output char_t [3:0] res);
    int         n;
    int         pads;
    logic [5:0] flush;
    logic       have_flush;
    n = 0;
    pads = 0;
    flush = 6'd0;
    have_flush = 1'b0;
    res = '0;
    case (grp_phase)
      PHASE_1: begin
        res[0].ch = B64_SET[{carry_nib[1:0], b[7:4]}];
        n = 1;
        carry_nib = b[3:0];
        grp_phase = PHASE_2;
        if (fin) begin
          flush = {b[3:0], 2'b00};
          have_flush = 1'b1;
          pads = 1;
        end
      end
      PHASE_2: begin
        res[0].ch = B64_SET[{carry_nib, b[7:6]}];
        res[1].ch = B64_SET[b[5:0]];
        res[1].fin = fin;
        n = 2;
        carry_nib = 4'h0;
        grp_phase = PHASE_0;
      end
      default: begin
        res[0].ch = B64_SET[b[7:2]];
        n = 1;
        carry_nib = {2'b00, b[1:0]};
        grp_phase = PHASE_1;
        if (fin) begin
          flush = {b[1:0], 4'h0};
          have_flush = 1'b1;
          pads = 2;
        end
      end
    endcase
    if (fin) begin
      if (!pad_on) pads = 0;
      if (have_flush) begin
        res[n].ch = B64_SET[flush];
        res[n].fin = (pads == 0);
        n++;
      end
      while (pads > 0) begin
        pads--;
        res[n].ch = PadChar;
        res[n].fin = (pads == 0);
        n++;
      end
      grp_phase = PHASE_0;
      carry_nib = 4'h0;
    end
    return n;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // transaction monitor: config, input prediction, output compare
  always @(posedge clk) begin
    char_t [3:0] res;
    char_t       c;
    char_t       got;
    int          n;
    dir_row_t    row;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) pad_on = cfg_data;
      if (in_tvalid && in_tready) begin
        n = encode_byte(in_tdata, in_tlast, res);
        if (in_cnt < DIR_N && DIR_TAB[in_cnt].chk) begin
          row = DIR_TAB[in_cnt];
          for (int k = 0; k < int'(row.cnt); k++) begin
            c.ch = row.text[8*(int'(row.cnt)-1-k) +: 8];
            c.fin = row.fin && (k == int'(row.cnt) - 1);
            chars_due.push_back(c);
          end
        end else begin
          for (int k = 0; k < n; k++) chars_due.push_back(res[k]);
        end
        in_cnt++;
      end
      if (out_tvalid && out_tready) begin
        got.ch = out_tdata;
        got.fin = out_tlast;
        if (chars_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected char 0x%02h last %b", got.ch, got.fin));
        end else begin
          c = chars_due.pop_front();
          if (got.ch !== c.ch)
            flag_mismatch($sformatf("char 0x%02h, want 0x%02h", got.ch, c.ch));
          if (got.fin !== c.fin)
            flag_mismatch($sformatf("last %b, want %b on 0x%02h", got.fin, c.fin, c.ch));
        end
      end
    end
  end

  // receiver stalls and run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (!cycle_cnt[9] && $urandom_range(0, 99) < 25) begin
      out_tready <= 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30) : $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    in_tdata <= b;
    in_tlast <= fin;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    gap = sender_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (chars_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_pad(input logic v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pad_cur = v;
    @(posedge clk);
  endtask

  initial begin
    int         len;
    int         cnt;
    int         r;
    logic [7:0] b;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_TAB[i].pad != pad_cur) begin
        wait_drained();
        write_pad(DIR_TAB[i].pad);
      end
      send_byte(DIR_TAB[i].b, DIR_TAB[i].fin);
    end
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_pad((ph == 0) ? 1'b0 : ((ph == 1) ? 1'b1 : 1'(($urandom_range(0, 1)))));
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        len = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 5) : $urandom_range(6, 16);
        burst = ($urandom_range(0, 3) == 0);
        for (int j = 0; j < len; j++) begin
          r = $urandom_range(0, 99);
          b = (r < 10) ? 8'h00 : ((r < 20) ? 8'hFF : 8'($urandom_range(0, 255)));
          send_byte(b, j == len - 1);
        end
        cnt += len;
      end
      burst = 1'b0;
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && chars_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
